// ===== sv/assert_macros.svh =====
// assertion macros used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

// ===== sv/c8ex_pkg.sv =====
// shared types and constants of the chip8 execute unit
`default_nettype none
package c8ex_pkg;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;
    localparam logic [1:0] ST_WAIT = 2'd3;

    localparam logic [11:0] START_RESET = 12'd512;
    localparam logic [11:0] FONT_RESET = 12'd80;

    localparam logic [0:0] REG_START = 1'b0;
    localparam logic [0:0] REG_FONT = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] opcode;
        logic [15:0] key_state;
        logic [7:0]  random_byte;
    } in_item_t;

    typedef struct packed {
        logic [11:0] next_pc;
        logic        write_valid;
        logic [11:0] write_addr;
        logic [7:0]  write_data;
        logic        clear_screen;
        logic [1:0]  status;
        logic        sound_on;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_BURST,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic burst_step;
        logic out_load;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic has_burst;
        logic burst_last;
    } stat_t;
endpackage
`default_nettype wire

// ===== sv/chip8_instruction_execute_unit.sv =====
// Executes one CHIP-8 instruction or timer tick per request. The accepted request is registered,
// the execute state decodes it and updates the register file, and the output register is then
// loaded once it is free to take the result. A new request is accepted only after that last
// result has been loaded into the output register. Fx33 yields three write results and
// Fx55 yields x+1, one per cycle while the result side takes them, from the output register.
`default_nettype none
`include "assert_macros.svh"
module chip8_instruction_execute_unit #(
    parameter int STACK_DEPTH = 16,
    parameter int ADDR_BITS = 12
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire c8ex_pkg::in_item_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output c8ex_pkg::out_item_t     m_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic [11:0] start_reg, font_reg;
    c8ex_pkg::ctrl_t ctrl;
    c8ex_pkg::stat_t st;
    logic out_free, m_valid_reg;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= c8ex_pkg::START_RESET;
            font_reg <= c8ex_pkg::FONT_RESET;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            if (paddr[2] == c8ex_pkg::REG_START) start_reg <= pwdata[11:0];
            else font_reg <= pwdata[11:0];
        end
    end
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == c8ex_pkg::REG_START) prdata = {20'd0, start_reg};
        else prdata = {20'd0, font_reg};
    end

    assign out_free = !m_valid_reg || m_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (ctrl.out_load) m_valid_reg <= 1'b1;
        else if (m_ready) m_valid_reg <= 1'b0;
    end
    assign m_valid = m_valid_reg;

    c8ex_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(s_valid), .out_free(out_free),
        .st(st), .s_ready(s_ready), .ctrl(ctrl)
    );

    c8ex_dpath #(.STACK_DEPTH(STACK_DEPTH), .ADDR_BITS(ADDR_BITS)) u_dpath (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .in_item(s_data),
        .start_address(start_reg), .font_base(font_reg), .st(st), .res(m_data)
    );

    `ASSERT_NEVER(a_load_busy, aclk, aresetn, ctrl.load && ctrl.out_load)
    `ASSERT_CLK(a_out_sets_valid, aclk, aresetn, ctrl.out_load |=> m_valid)
    `ASSERT_NEVER(a_ready_exec, aclk, aresetn, s_ready && ctrl.exec)
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))
endmodule
`default_nettype wire

// ===== sv/c8ex_ctrl.sv =====
// controller state machine of the chip8 execute unit
`default_nettype none
module c8ex_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_fire,
    input  wire logic           out_free,
    input  wire c8ex_pkg::stat_t st,
    output logic                s_ready,
    output c8ex_pkg::ctrl_t     ctrl
);
    c8ex_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= c8ex_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            c8ex_pkg::S_IDLE: begin
                if (in_fire) state_next = c8ex_pkg::S_EXEC;
            end
            c8ex_pkg::S_EXEC: begin
                state_next = st.has_burst ? c8ex_pkg::S_BURST : c8ex_pkg::S_OUT;
            end
            c8ex_pkg::S_BURST: begin
                if (out_free && st.burst_last) state_next = c8ex_pkg::S_IDLE;
            end
            c8ex_pkg::S_OUT: begin
                if (out_free) state_next = c8ex_pkg::S_IDLE;
            end
            default: state_next = c8ex_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == c8ex_pkg::S_IDLE);
        ctrl.load = s_ready && in_fire;
        ctrl.exec = (state_reg == c8ex_pkg::S_EXEC);
        ctrl.burst_step = (state_reg == c8ex_pkg::S_BURST) && out_free;
        ctrl.out_load = ctrl.burst_step || ((state_reg == c8ex_pkg::S_OUT) && out_free);
    end
endmodule
`default_nettype wire

// ===== sv/c8ex_dpath.sv =====
// datapath of the chip8 execute unit: registers, stack, timers, alu
`default_nettype none
module c8ex_dpath #(
    parameter int STACK_DEPTH = 16,
    parameter int ADDR_BITS = 12
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire c8ex_pkg::ctrl_t   ctrl,
    input  wire c8ex_pkg::in_item_t in_item,
    input  wire logic [11:0]       start_address,
    input  wire logic [11:0]       font_base,
    output c8ex_pkg::stat_t        st,
    output c8ex_pkg::out_item_t    res
);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    c8ex_pkg::in_item_t item_reg;
    logic [7:0] v_reg [16];
    logic [ADDR_BITS-1:0] i_reg, pc_reg;
    logic [SPW-1:0] sp_reg;
    logic [ADDR_BITS-1:0] stk_reg [STACK_DEPTH];
    logic [7:0] dt_reg, st_reg;
    // pending pieces of the result and burst counters
    logic [11:0] npc_reg;
    logic clr_reg;
    logic [1:0] sts_reg;
    logic bcd_reg;
    logic [3:0] cnt_reg, cnt_max_reg;
    logic [7:0] bcd_d [3];

    logic [3:0] x, y, n;
    logic [7:0] kk, vx, vy;
    logic [11:0] nnn;
    logic [ADDR_BITS-1:0] pc2, npc;
    logic [1:0] sts;
    logic clr, wx, wf, burst, bcd;
    logic [7:0] vxn, vfn;
    logic [8:0] sum;
    logic [3:0] key_idx;
    logic pressed;
    logic [ADDR_BITS-1:0] skip;
    logic [1:0] bcd_h;
    logic [7:0] bcd_r;
    logic [3:0] bcd_t;
    logic [7:0] bcd_o;

    assign x = item_reg.opcode[11:8];
    assign y = item_reg.opcode[7:4];
    assign n = item_reg.opcode[3:0];
    assign kk = item_reg.opcode[7:0];
    assign nnn = item_reg.opcode[11:0];
    assign vx = v_reg[x];
    assign vy = v_reg[y];
    assign pc2 = pc_reg + ADDR_BITS'(2);
    assign skip = pc_reg + ADDR_BITS'(4);
    assign sum = {1'b0, vx} + {1'b0, vy};
    assign pressed = item_reg.key_state[vx[3:0]] && (vx[7:4] == 4'd0);

    always_comb begin
        key_idx = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (item_reg.key_state[k]) key_idx = 4'(k);
        end
    end

    // decimal digits of vx by compare and subtract
    always_comb begin
        priority if (vx >= 8'd200) begin
            bcd_h = 2'd2; bcd_r = vx - 8'd200;
        end else if (vx >= 8'd100) begin
            bcd_h = 2'd1; bcd_r = vx - 8'd100;
        end else begin
            bcd_h = 2'd0; bcd_r = vx;
        end
        bcd_t = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (bcd_r >= 8'(10 * k)) bcd_t = 4'(k);
        end
        bcd_o = bcd_r - 8'({bcd_t, 3'b000} + {3'd0, bcd_t, 1'b0});
    end

    always_comb begin
        npc = pc2; sts = c8ex_pkg::ST_OK; clr = 1'b0; wx = 1'b0; wf = 1'b0;
        vxn = 8'd0; vfn = 8'd0; burst = 1'b0; bcd = 1'b0;
        unique case (item_reg.opcode[15:12])
            4'h0: begin
                if (item_reg.opcode == 16'h00E0) clr = 1'b1;
                else if (item_reg.opcode == 16'h00EE) begin
                    if (sp_reg == '0) sts = c8ex_pkg::ST_INVALID;
                    else npc = stk_reg[SIW'(sp_reg - SPW'(1))];
                end else if (!(nnn > 12'h1FF && nnn < 12'hFFF)) sts = c8ex_pkg::ST_INVALID;
            end
            4'h1: npc = ADDR_BITS'(nnn);
            4'h2: begin
                if (sp_reg >= SPW'(STACK_DEPTH)) sts = c8ex_pkg::ST_INVALID;
                else npc = ADDR_BITS'(nnn);
            end
            4'h3: if (vx == kk) npc = skip;
            4'h4: if (vx != kk) npc = skip;
            4'h5: begin
                if (n != 4'd0) sts = c8ex_pkg::ST_INVALID;
                else if (vx == vy) npc = skip;
            end
            4'h6: begin wx = 1'b1; vxn = kk; end
            4'h7: begin wx = 1'b1; vxn = vx + kk; end
            4'h8: begin
                wx = 1'b1;
                unique case (n)
                    4'h0: vxn = vy;
                    4'h1: vxn = vx | vy;
                    4'h2: vxn = vx & vy;
                    4'h3: vxn = vx ^ vy;
                    4'h4: begin vxn = sum[7:0]; wf = 1'b1; vfn = {7'd0, sum[8]}; end
                    4'h5: begin vxn = vx - vy; wf = 1'b1; vfn = {7'd0, vx > vy}; end
                    4'h6: begin vxn = vx >> 1; wf = 1'b1; vfn = {7'd0, vx[0]}; end
                    4'h7: begin vxn = vy - vx; wf = 1'b1; vfn = {7'd0, vy > vx}; end
                    4'hE: begin vxn = vx << 1; wf = 1'b1; vfn = {7'd0, vx[7]}; end
                    default: begin wx = 1'b0; sts = c8ex_pkg::ST_INVALID; end
                endcase
            end
            4'h9: begin
                if (n != 4'd0) sts = c8ex_pkg::ST_INVALID;
                else if (vx != vy) npc = skip;
            end
            4'hA: ;
            4'hB: npc = ADDR_BITS'(nnn) + ADDR_BITS'(v_reg[0]);
            4'hC: begin wx = 1'b1; vxn = item_reg.random_byte & kk; end
            4'hD: sts = c8ex_pkg::ST_UNSUP;
            4'hE: begin
                if (kk == 8'h9E) begin if (pressed) npc = skip; end
                else if (kk == 8'hA1) begin if (!pressed) npc = skip; end
                else sts = c8ex_pkg::ST_INVALID;
            end
            default: begin
                unique case (kk)
                    8'h07: begin wx = 1'b1; vxn = dt_reg; end
                    8'h0A: begin
                        if (item_reg.key_state == 16'd0) begin
                            npc = pc_reg; sts = c8ex_pkg::ST_WAIT;
                        end else begin wx = 1'b1; vxn = {4'd0, key_idx}; end
                    end
                    8'h15, 8'h18, 8'h1E, 8'h29: ;
                    8'h33: begin burst = 1'b1; bcd = 1'b1; end
                    8'h55: burst = 1'b1;
                    8'h65: sts = c8ex_pkg::ST_UNSUP;
                    default: sts = c8ex_pkg::ST_INVALID;
                endcase
            end
        endcase
    end

    assign st.burst_last = (cnt_reg == cnt_max_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.load) item_reg <= in_item;
        if (ctrl.exec) begin
            npc_reg <= 12'(npc);
            clr_reg <= clr;
            sts_reg <= sts;
            bcd_reg <= bcd;
            cnt_reg <= 4'd0;
            cnt_max_reg <= bcd ? 4'd2 : (burst ? x : 4'd0);
            bcd_d[0] <= {6'd0, bcd_h};
            bcd_d[1] <= {4'd0, bcd_t};
            bcd_d[2] <= bcd_o;
        end
        if (ctrl.burst_step) cnt_reg <= cnt_reg + 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 16; k++) v_reg[k] <= 8'd0;
            i_reg <= '0;
            pc_reg <= ADDR_BITS'(start_address);
            sp_reg <= '0;
            for (int k = 0; k < STACK_DEPTH; k++) stk_reg[k] <= '0;
            dt_reg <= 8'd0;
            st_reg <= 8'd0;
        end else if (ctrl.exec) begin
            if (item_reg.mode) begin
                if (dt_reg != 8'd0) dt_reg <= dt_reg - 8'd1;
                if (st_reg != 8'd0) st_reg <= st_reg - 8'd1;
            end else begin
                pc_reg <= npc;
                if (wx) v_reg[x] <= vxn;
                if (wf) v_reg[15] <= vfn;
                if (item_reg.opcode == 16'h00EE && sp_reg != '0) sp_reg <= sp_reg - SPW'(1);
                if (item_reg.opcode[15:12] == 4'h2 && sp_reg < SPW'(STACK_DEPTH)) begin
                    stk_reg[SIW'(sp_reg)] <= pc2;
                    sp_reg <= sp_reg + SPW'(1);
                end
                if (item_reg.opcode[15:12] == 4'hA) i_reg <= ADDR_BITS'(nnn);
                if (item_reg.opcode[15:12] == 4'hF) begin
                    unique case (kk)
                        8'h15: dt_reg <= vx;
                        8'h18: st_reg <= vx;
                        8'h1E: i_reg <= i_reg + ADDR_BITS'(vx);
                        8'h29: i_reg <= ADDR_BITS'(font_base) + ADDR_BITS'({vx[3:0], 2'b00})
                                        + ADDR_BITS'(vx[3:0]);
                        default: ;
                    endcase
                end
            end
        end
    end

    logic tick_reg;
    always_ff @(posedge aclk) begin
        if (ctrl.exec) tick_reg <= item_reg.mode;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            res.sound_on <= (st_reg != 8'd0);
            if (tick_reg) begin
                res.next_pc <= 12'(pc_reg);
                res.write_valid <= 1'b0; res.write_addr <= 12'd0; res.write_data <= 8'd0;
                res.clear_screen <= 1'b0; res.status <= c8ex_pkg::ST_OK; res.last <= 1'b1;
            end else if (ctrl.burst_step) begin
                res.next_pc <= npc_reg;
                res.write_valid <= 1'b1;
                res.write_addr <= 12'(i_reg + ADDR_BITS'(cnt_reg));
                res.write_data <= bcd_reg ? bcd_d[cnt_reg[1:0] == 2'd3 ? 2'd2 : cnt_reg[1:0]]
                                          : v_reg[cnt_reg];
                res.clear_screen <= 1'b0; res.status <= c8ex_pkg::ST_OK;
                res.last <= st.burst_last;
            end else begin
                res.next_pc <= npc_reg;
                res.write_valid <= 1'b0; res.write_addr <= 12'd0; res.write_data <= 8'd0;
                res.clear_screen <= clr_reg; res.status <= sts_reg; res.last <= 1'b1;
            end
        end
    end

    assign st.has_burst = burst && !item_reg.mode;
endmodule
`default_nettype wire

// ===== sim/chip8_instruction_execute_unit_checker.sv =====
// checker for the chip8 execute unit: predicts results per request and compares them
`default_nettype none
module chip8_instruction_execute_unit_checker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire c8ex_pkg::in_item_t  s_data,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire c8ex_pkg::out_item_t m_data,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output int                       fail_count,
    output int                       pending_count
);
    localparam int STACK_DEPTH = 16;

    logic [11:0] start_addr_q;
    logic [11:0] font_base_q;
    logic [7:0]  vreg [16];
    logic [11:0] idx_reg;
    logic [11:0] pc;
    int          sp;
    logic [11:0] ret_stack [STACK_DEPTH];
    logic [7:0]  delay_tmr;
    logic [7:0]  sound_tmr;

    c8ex_pkg::out_item_t expected_results [$];

    assign pending_count = expected_results.size();

    function automatic c8ex_pkg::out_item_t make_result(logic [11:0] npc, logic wv,
                                                        logic [11:0] wa, logic [7:0] wd,
                                                        logic clr, logic [1:0] st);
        c8ex_pkg::out_item_t r;
        r.next_pc      = npc;
        r.write_valid  = wv;
        r.write_addr   = wa;
        r.write_data   = wd;
        r.clear_screen = clr;
        r.status       = st;
        r.sound_on     = (sound_tmr != 8'd0);
        r.last         = 1'b0;
        return r;
    endfunction

    task automatic execute_request(input c8ex_pkg::in_item_t req);
        logic [15:0] op;
        logic [3:0]  x, y, n;
        logic [7:0]  kk, vx, vy;
        logic [11:0] nnn, npc;
        logic [1:0]  st;
        logic        clr, pressed;
        logic [11:0] wa [16];
        logic [7:0]  wd [16];
        int          nw;
        c8ex_pkg::out_item_t r;
        op = req.opcode;
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        kk = op[7:0];
        nnn = op[11:0];
        vx = vreg[x];
        vy = vreg[y];
        npc = pc + 12'd2;
        st = c8ex_pkg::ST_OK;
        clr = 1'b0;
        nw = 0;
        if (req.mode) begin
            if (delay_tmr != 8'd0) delay_tmr = delay_tmr - 8'd1;
            if (sound_tmr != 8'd0) sound_tmr = sound_tmr - 8'd1;
            r = make_result(pc, 1'b0, 12'd0, 8'd0, 1'b0, c8ex_pkg::ST_OK);
            r.last = 1'b1;
            expected_results.push_back(r);
            return;
        end
        case (op[15:12])
            4'h0: begin
                if (op == 16'h00E0) begin
                    clr = 1'b1;
                end else if (op == 16'h00EE) begin
                    if (sp == 0) st = c8ex_pkg::ST_INVALID;
                    else begin
                        sp--;
                        npc = ret_stack[sp];
                    end
                end else if (!(nnn > 12'h1FF && nnn < 12'hFFF)) begin
                    st = c8ex_pkg::ST_INVALID;
                end
            end
            4'h1: npc = nnn;
            4'h2: begin
                if (sp >= STACK_DEPTH) st = c8ex_pkg::ST_INVALID;
                else begin
                    ret_stack[sp] = npc;
                    sp++;
                    npc = nnn;
                end
            end
            4'h3: if (vx == kk) npc = npc + 12'd2;
            4'h4: if (vx != kk) npc = npc + 12'd2;
            4'h5: begin
                if (n != 4'd0) st = c8ex_pkg::ST_INVALID;
                else if (vx == vy) npc = npc + 12'd2;
            end
            4'h6: vreg[x] = kk;
            4'h7: vreg[x] = vx + kk;
            4'h8: begin
                case (n)
                    4'h0: vreg[x] = vy;
                    4'h1: vreg[x] = vx | vy;
                    4'h2: vreg[x] = vx & vy;
                    4'h3: vreg[x] = vx ^ vy;
                    4'h4: begin
                        vreg[x] = vx + vy;
                        vreg[15] = ({1'b0, vx} + {1'b0, vy} > 9'd255) ? 8'd1 : 8'd0;
                    end
                    4'h5: begin
                        vreg[x] = vx - vy;
                        vreg[15] = (vx > vy) ? 8'd1 : 8'd0;
                    end
                    4'h6: begin
                        vreg[x] = vx >> 1;
                        vreg[15] = {7'd0, vx[0]};
                    end
                    4'h7: begin
                        vreg[x] = vy - vx;
                        vreg[15] = (vy > vx) ? 8'd1 : 8'd0;
                    end
                    4'hE: begin
                        vreg[x] = vx << 1;
                        vreg[15] = {7'd0, vx[7]};
                    end
                    default: st = c8ex_pkg::ST_INVALID;
                endcase
            end
            4'h9: begin
                if (n != 4'd0) st = c8ex_pkg::ST_INVALID;
                else if (vx != vy) npc = npc + 12'd2;
            end
            4'hA: idx_reg = nnn;
            4'hB: npc = nnn + {4'd0, vreg[0]};
            4'hC: vreg[x] = req.random_byte & kk;
            4'hD: st = c8ex_pkg::ST_UNSUP;
            4'hE: begin
                pressed = (vx < 8'd16) && req.key_state[vx[3:0]];
                if (kk == 8'h9E) begin
                    if (pressed) npc = npc + 12'd2;
                end else if (kk == 8'hA1) begin
                    if (!pressed) npc = npc + 12'd2;
                end else st = c8ex_pkg::ST_INVALID;
            end
            default: begin
                case (kk)
                    8'h07: vreg[x] = delay_tmr;
                    8'h0A: begin
                        if (req.key_state == 16'd0) begin
                            npc = pc;
                            st = c8ex_pkg::ST_WAIT;
                        end else begin
                            for (int i = 15; i >= 0; i--)
                                if (req.key_state[i]) vreg[x] = 8'(i);
                        end
                    end
                    8'h15: delay_tmr = vx;
                    8'h18: sound_tmr = vx;
                    8'h1E: idx_reg = idx_reg + {4'd0, vx};
                    8'h29: idx_reg = font_base_q + 12'd5 * {8'd0, vx[3:0]};
                    8'h33: begin
                        wa[0] = idx_reg;
                        wd[0] = 8'(vx / 100);
                        wa[1] = idx_reg + 12'd1;
                        wd[1] = 8'((vx / 10) % 10);
                        wa[2] = idx_reg + 12'd2;
                        wd[2] = 8'(vx % 10);
                        nw = 3;
                    end
                    8'h55: begin
                        for (int k = 0; k <= int'(x); k++) begin
                            wa[k] = idx_reg + 12'(k);
                            wd[k] = vreg[k];
                        end
                        nw = int'(x) + 1;
                    end
                    8'h65: st = c8ex_pkg::ST_UNSUP;
                    default: st = c8ex_pkg::ST_INVALID;
                endcase
            end
        endcase
        pc = npc;
        if (nw == 0) begin
            r = make_result(npc, 1'b0, 12'd0, 8'd0, clr, st);
            r.last = 1'b1;
            expected_results.push_back(r);
        end else begin
            for (int k = 0; k < nw; k++) begin
                r = make_result(npc, 1'b1, wa[k], wd[k], 1'b0, c8ex_pkg::ST_OK);
                r.last = (k == nw - 1);
                expected_results.push_back(r);
            end
        end
    endtask

    task automatic compare_result(input c8ex_pkg::out_item_t got);
        c8ex_pkg::out_item_t want;
        if (expected_results.size() == 0) begin
            $error("result with nothing expected: %p", got);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.next_pc !== want.next_pc) begin
            $error("next_pc expected %0h got %0h", want.next_pc, got.next_pc);
            fail_count++;
        end
        if (got.write_valid !== want.write_valid) begin
            $error("write_valid expected %0b got %0b", want.write_valid, got.write_valid);
            fail_count++;
        end
        if (got.write_addr !== want.write_addr) begin
            $error("write_addr expected %0h got %0h", want.write_addr, got.write_addr);
            fail_count++;
        end
        if (got.write_data !== want.write_data) begin
            $error("write_data expected %0h got %0h", want.write_data, got.write_data);
            fail_count++;
        end
        if (got.clear_screen !== want.clear_screen) begin
            $error("clear_screen expected %0b got %0b", want.clear_screen, got.clear_screen);
            fail_count++;
        end
        if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.sound_on !== want.sound_on) begin
            $error("sound_on expected %0b got %0b", want.sound_on, got.sound_on);
            fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last expected %0b got %0b", want.last, got.last);
            fail_count++;
        end
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            start_addr_q = c8ex_pkg::START_RESET;
            font_base_q = c8ex_pkg::FONT_RESET;
            for (int i = 0; i < 16; i++) vreg[i] = 8'd0;
            for (int i = 0; i < STACK_DEPTH; i++) ret_stack[i] = 12'd0;
            idx_reg = 12'd0;
            pc = c8ex_pkg::START_RESET;
            sp = 0;
            delay_tmr = 8'd0;
            sound_tmr = 8'd0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) compare_result(m_data);
            if (psel && penable && pwrite) begin
                if (paddr[2] == c8ex_pkg::REG_START) start_addr_q = pwdata[11:0];
                else font_base_q = pwdata[11:0];
            end
            if (s_valid && s_ready) execute_request(s_data);
        end
    end
endmodule
`default_nettype wire

// ===== sim/chip8_instruction_execute_unit_tb.sv =====
// testbench top for the chip8 execute unit: stimulus, register writes and verdict
`default_nettype none
module chip8_instruction_execute_unit_tb;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    c8ex_pkg::in_item_t  s_data;
    logic        m_valid;
    logic        m_ready;
    c8ex_pkg::out_item_t m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_count;
    int          idle_cycles;
    bit          quiet_phase;
    bit          hold_sink;
    bit          hold_done;

    chip8_instruction_execute_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    chip8_instruction_execute_unit_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .fail_count(fail_count), .pending_count(pending_count)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // result side: random stall bursts, one long hold during the random request phase
    initial begin
        int burst;
        m_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_sink && !hold_done) begin
                m_ready <= 1'b0;
                repeat (60) @(negedge aclk);
                hold_done = 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 10);
                m_ready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake and no register access
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("chip8_instruction_execute_unit_tb failed");
                $finish;
            end
        end
    end

    // request signals are driven with blocking writes so back to back requests
    // can drop and raise valid at the same falling edge
    task automatic send_request(input c8ex_pkg::in_item_t req);
        int gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send_op(input logic [15:0] op, input logic [15:0] keys);
        c8ex_pkg::in_item_t req;
        req.mode = 1'b0;
        req.opcode = op;
        req.key_state = keys;
        req.random_byte = 8'($urandom);
        send_request(req);
    endtask

    task automatic send_tick();
        c8ex_pkg::in_item_t req;
        req.mode = 1'b1;
        req.opcode = 16'($urandom);
        req.key_state = 16'($urandom);
        req.random_byte = 8'($urandom);
        send_request(req);
    endtask

    task automatic write_reg(input logic [0:0] reg_sel, input logic [11:0] value);
        while (pending_count != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= {20'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [15:0] random_opcode();
        logic [3:0]  x;
        logic [15:0] r;
        x = 4'($urandom);
        r = 16'($urandom);
        case ($urandom_range(0, 19))
            0:  return 16'h00E0;
            1:  return 16'h00EE;
            2:  return {4'h2, 12'($urandom_range(12'h200, 12'hFFE))};
            3:  return {4'h1, 12'($urandom_range(12'h200, 12'hFFE))};
            4:  return {4'h6, r[11:0]};
            5:  return {4'h7, r[11:0]};
            6:  return {4'h8, r[11:4], 4'($urandom_range(0, 7))};
            7:  return {4'h8, r[11:4], 4'hE};
            8:  return {4'h3 + 4'($urandom_range(0, 1)), r[11:0]};
            9:  return {4'h5 + 4'($urandom_range(0, 1)) * 4'h4, r[11:4], 4'h0};
            10: return {4'hE, x, ($urandom_range(0, 1) ? 8'h9E : 8'hA1)};
            11: return {4'hF, x, 8'h33};
            12: return {4'hF, x, 8'h55};
            13: return {4'hF, x, 8'h0A};
            14: return {4'hF, x, 8'h15 + 8'($urandom_range(0, 1)) * 8'h03};
            15: return {4'hF, x, 8'h1E};
            16: return {4'hF, x, 8'h29};
            17: return {4'hC, r[11:0]};
            18: return {4'hF, x, 8'h07};
            default: return r;
        endcase
    endfunction

    initial begin
        logic [15:0] keys;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet_phase = 1'b0;
        hold_sink = 1'b0;
        idle_cycles = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes and special cases
        send_op(16'h60FF, 16'h0000);
        send_op(16'h61FF, 16'h0000);
        send_op(16'h8014, 16'h0000);
        send_op(16'h8017, 16'h0000);
        send_op(16'h8015, 16'h0000);
        send_op(16'h810E, 16'h0000);
        send_op(16'h8106, 16'h0000);
        send_op(16'h8F1E, 16'h0000);
        send_op(16'h80F7, 16'h0000);
        send_op(16'hA000, 16'h0000);
        send_op(16'hF033, 16'h0000);
        send_op(16'hAFFE, 16'h0000);
        send_op(16'hFF55, 16'h0000);
        send_op(16'hF10A, 16'h0000);
        send_op(16'hF10A, 16'h8000);
        send_op(16'hE19E, 16'hFFFF);
        send_op(16'hE0A1, 16'hFFFF);
        send_op(16'h00EE, 16'h0000);
        send_op(16'h0000, 16'h0000);
        send_op(16'h0FFF, 16'h0000);
        send_op(16'h5001, 16'h0000);
        send_op(16'hD123, 16'h0000);
        send_op(16'hF065, 16'h0000);
        send_op(16'h62FF, 16'h0000);
        send_op(16'hF218, 16'h0000);
        send_tick();

        for (int i = 0; i < 17; i++) send_op(16'h2FFE, 16'h0000);
        for (int i = 0; i < 17; i++) send_op(16'h00EE, 16'h0000);

        write_reg(c8ex_pkg::REG_FONT, 12'hFFF);
        send_op(16'hF229, 16'h0000);
        write_reg(c8ex_pkg::REG_FONT, 12'h000);
        send_op(16'hF029, 16'h0000);
        write_reg(c8ex_pkg::REG_START, 12'hFFF);
        write_reg(c8ex_pkg::REG_FONT, 12'h123);

        hold_sink = 1'b1;
        for (int i = 0; i < 270; i++) begin
            if (i == 230) quiet_phase = 1'b1;
            keys = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
            if ($urandom_range(0, 7) == 0) send_tick();
            else send_op(random_opcode(), keys);
            if (i == 160) begin
                write_reg(c8ex_pkg::REG_START, 12'h000);
                write_reg(c8ex_pkg::REG_FONT, 12'h050);
            end
        end

        while (pending_count != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0) begin
            $display("chip8_instruction_execute_unit_tb passed");
        end else begin
            $display("chip8_instruction_execute_unit_tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== chip8_instruction_execute_unit.f =====
+incdir+sv
sv/c8ex_pkg.sv
sv/c8ex_ctrl.sv
sv/c8ex_dpath.sv
sv/chip8_instruction_execute_unit.sv
sim/chip8_instruction_execute_unit_checker.sv
sim/chip8_instruction_execute_unit_tb.sv
